>>> rtl/m3inv_pkg.sv
// Shared constants and types of the 3x3 matrix inverse core.
`timescale 1ns / 1ps
package m3inv_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int NUM_ELEM  = 9;
   localparam int NUM_PROD  = 2 * NUM_ELEM;
   localparam int COF_W     = 2 * DATA_W;
   localparam int DET_W     = 98;
   localparam int DMAG_W    = DET_W - 1;
   localparam int REM_W     = DMAG_W + 1;
   localparam int QUO_W     = DATA_W;
   localparam int NUM_W     = COF_W + 2 * FRAC_BITS;
   localparam int LOW_W     = QUO_W;

   // Element indexes p, q, r, s of cofactor k = p*q - r*s, row-major order.
   localparam logic [3:0] COF_IDX [NUM_ELEM][4] = '{
      '{4'd4, 4'd8, 4'd5, 4'd7},
      '{4'd5, 4'd6, 4'd3, 4'd8},
      '{4'd3, 4'd7, 4'd4, 4'd6},
      '{4'd2, 4'd7, 4'd1, 4'd8},
      '{4'd0, 4'd8, 4'd2, 4'd6},
      '{4'd1, 4'd6, 4'd0, 4'd7},
      '{4'd1, 4'd5, 4'd2, 4'd4},
      '{4'd2, 4'd3, 4'd0, 4'd5},
      '{4'd0, 4'd4, 4'd1, 4'd3}
   };

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [LOW_W-1:0] low;
      logic [QUO_W-1:0] quo;
      logic             neg;
      logic             ovf;
   } lane_type;

   typedef struct packed {
      lane_type [NUM_ELEM-1:0] lane;
      logic [DMAG_W-1:0]       dmag;
      logic                    singular;
   } stage_type;

   typedef struct packed {
      logic en;
      logic valid;
   } ctrl_type;

endpackage

>>> rtl/m3inv_if.sv
// Request and response channel interfaces of the 3x3 matrix inverse core.
`timescale 1ns / 1ps
interface m3inv_req_if;
   logic valid;
   logic ready;
   logic signed [m3inv_pkg::DATA_W-1:0] in_r0c0, in_r0c1, in_r0c2;
   logic signed [m3inv_pkg::DATA_W-1:0] in_r1c0, in_r1c1, in_r1c2;
   logic signed [m3inv_pkg::DATA_W-1:0] in_r2c0, in_r2c1, in_r2c2;
   modport source (output valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
                   in_r2c0, in_r2c1, in_r2c2, input ready);
   modport sink (input valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
                 in_r2c0, in_r2c1, in_r2c2, output ready);
endinterface

interface m3inv_rsp_if;
   logic valid;
   logic ready;
   logic signed [m3inv_pkg::DATA_W-1:0] out_r0c0, out_r0c1, out_r0c2;
   logic signed [m3inv_pkg::DATA_W-1:0] out_r1c0, out_r1c1, out_r1c2;
   logic signed [m3inv_pkg::DATA_W-1:0] out_r2c0, out_r2c1, out_r2c2;
   logic singular;
   modport source (output valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1,
                   out_r1c2, out_r2c0, out_r2c1, out_r2c2, singular, input ready);
   modport sink (input valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1,
                 out_r1c2, out_r2c0, out_r2c1, out_r2c2, singular, output ready);
endinterface

>>> rtl/matrix3x3_inverse_core.sv
// Top level of the pipelined 3x3 matrix inverse (adjugate over determinant).
//
//   channel  direction  handshake            payload
//   req_ch   in         valid/ready          in_r0c0 .. in_r2c2, signed Q16.16
//   rsp_ch   out        valid/ready          out_r0c0 .. out_r2c2, singular
//
// One request enters per cycle while the pipeline is not held (see below).
// Seven front stages form products, cofactors, determinant, magnitudes and
// overflow flags, then the 32 quotient-bit stages of the nine lane dividers.
// Reset clears all valid bits; the pipeline holds as a whole while the
// response register is full and not taken, so nothing is dropped or repeated.
`timescale 1ns / 1ps
module matrix3x3_inverse_core (
   input  logic        clock,
   input  logic        reset,
   m3inv_req_if.sink   req_ch,
   m3inv_rsp_if.source rsp_ch
);

   localparam int NE = m3inv_pkg::NUM_ELEM;
   localparam int DW = m3inv_pkg::DATA_W;
   localparam int CW = m3inv_pkg::COF_W;
   localparam int TW = m3inv_pkg::DET_W;
   localparam int QW = m3inv_pkg::QUO_W;

   logic en;
   logic signed [DW-1:0] a_in [NE];

   logic                 v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;
   logic signed [CW-1:0] prod1_ff [m3inv_pkg::NUM_PROD];
   logic signed [CW-1:0] prod1_in [m3inv_pkg::NUM_PROD];
   logic signed [DW-1:0] a0_1_ff [3];
   logic signed [DW-1:0] a0_2_ff [3];
   logic signed [CW-1:0] cof2_ff [NE];
   logic signed [CW-1:0] cof3_ff [NE];
   logic signed [CW-1:0] cof4_ff [NE];
   logic signed [CW:0]   plo3_ff [3];
   logic signed [CW-1:0] phi3_ff [3];
   logic signed [TW-1:0] term4_ff [3];
   logic signed [TW-1:0] det5_ff;
   logic [CW-1:0]        cmag5_ff [NE];
   logic                 cneg5_ff [NE];
   m3inv_pkg::stage_type s6_ff, s6_in, s7_ff, s7_in;

   m3inv_pkg::stage_type div_stage [QW+1];
   logic                 div_valid [QW+1];

   logic                 rsp_valid_ff;
   logic signed [DW-1:0] out_ff [NE];
   logic signed [DW-1:0] out_in [NE];
   logic                 singular_ff;

   assign en = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = en;

   assign a_in[0] = req_ch.in_r0c0;
   assign a_in[1] = req_ch.in_r0c1;
   assign a_in[2] = req_ch.in_r0c2;
   assign a_in[3] = req_ch.in_r1c0;
   assign a_in[4] = req_ch.in_r1c1;
   assign a_in[5] = req_ch.in_r1c2;
   assign a_in[6] = req_ch.in_r2c0;
   assign a_in[7] = req_ch.in_r2c1;
   assign a_in[8] = req_ch.in_r2c2;

   always_comb begin
      for (int k = 0; k < NE; k++) begin
         prod1_in[2*k]   = a_in[m3inv_pkg::COF_IDX[k][0]] * a_in[m3inv_pkg::COF_IDX[k][1]];
         prod1_in[2*k+1] = a_in[m3inv_pkg::COF_IDX[k][2]] * a_in[m3inv_pkg::COF_IDX[k][3]];
      end
   end

   // Stage 6: determinant magnitude, transpose the cofactors into lanes.
   always_comb begin
      logic signed [TW-1:0]           dabs;
      logic [m3inv_pkg::NUM_W-1:0]    num;
      dabs = det5_ff[TW-1] ? -det5_ff : det5_ff;
      s6_in.dmag     = dabs[m3inv_pkg::DMAG_W-1:0];
      s6_in.singular = (det5_ff == '0);
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            num = {cmag5_ff[j*3+i], {(2*m3inv_pkg::FRAC_BITS){1'b0}}};
            s6_in.lane[i*3+j].rem = m3inv_pkg::REM_W'(num[m3inv_pkg::NUM_W-1:QW]);
            s6_in.lane[i*3+j].low = num[QW-1:0];
            s6_in.lane[i*3+j].quo = '0;
            s6_in.lane[i*3+j].neg = cneg5_ff[j*3+i] ^ det5_ff[TW-1];
            s6_in.lane[i*3+j].ovf = 1'b0;
         end
      end
   end

   // Stage 7: a quotient of 2^32 or more saturates.
   always_comb begin
      s7_in = s6_ff;
      for (int l = 0; l < NE; l++) begin
         s7_in.lane[l].ovf = (s6_ff.lane[l].rem >= {1'b0, s6_ff.dmag});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_ch.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
      if (en) begin
         prod1_ff <= prod1_in;
         for (int k = 0; k < 3; k++) begin
            a0_1_ff[k] <= a_in[k];
            a0_2_ff[k] <= a0_1_ff[k];
            plo3_ff[k] <= a0_2_ff[k] * $signed({1'b0, cof2_ff[k][DW-1:0]});
            phi3_ff[k] <= a0_2_ff[k] * $signed(cof2_ff[k][CW-1:DW]);
            term4_ff[k] <= (TW'(phi3_ff[k]) <<< DW) + TW'(plo3_ff[k]);
         end
         for (int k = 0; k < NE; k++) begin
            cof2_ff[k]  <= prod1_ff[2*k] - prod1_ff[2*k+1];
            cmag5_ff[k] <= cof4_ff[k][CW-1] ? CW'(-cof4_ff[k]) : cof4_ff[k];
            cneg5_ff[k] <= cof4_ff[k][CW-1];
         end
         cof3_ff <= cof2_ff;
         cof4_ff <= cof3_ff;
         det5_ff <= term4_ff[0] + term4_ff[1] + term4_ff[2];
         s6_ff   <= s6_in;
         s7_ff   <= s7_in;
      end
   end

   assign div_stage[0] = s7_ff;
   assign div_valid[0] = v7_ff;

   for (genvar g = 0; g < QW; g++) begin : g_div
      m3inv_pkg::ctrl_type ctrl;
      assign ctrl.en    = en;
      assign ctrl.valid = div_valid[g];
      m3inv_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .stage_in  (div_stage[g]),
         .valid_out (div_valid[g+1]),
         .stage_out (div_stage[g+1])
      );
   end

   // Final stage: sign, saturation, singular zeroing.
   always_comb begin
      logic [QW-1:0] q;
      for (int l = 0; l < NE; l++) begin
         q = div_stage[QW].lane[l].quo;
         if (div_stage[QW].singular) begin
            out_in[l] = '0;
         end else if (div_stage[QW].lane[l].neg) begin
            if (div_stage[QW].lane[l].ovf || q > {1'b1, {(QW-1){1'b0}}}) begin
               out_in[l] = {1'b1, {(DW-1){1'b0}}};
            end else begin
               out_in[l] = -$signed(q);
            end
         end else begin
            if (div_stage[QW].lane[l].ovf || q[QW-1]) begin
               out_in[l] = {1'b0, {(DW-1){1'b1}}};
            end else begin
               out_in[l] = $signed(q);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= div_valid[QW];
      end
      if (en) begin
         out_ff      <= out_in;
         singular_ff <= div_stage[QW].singular;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.singular = singular_ff;
   assign rsp_ch.out_r0c0 = out_ff[0];
   assign rsp_ch.out_r0c1 = out_ff[1];
   assign rsp_ch.out_r0c2 = out_ff[2];
   assign rsp_ch.out_r1c0 = out_ff[3];
   assign rsp_ch.out_r1c1 = out_ff[4];
   assign rsp_ch.out_r1c2 = out_ff[5];
   assign rsp_ch.out_r2c0 = out_ff[6];
   assign rsp_ch.out_r2c1 = out_ff[7];
   assign rsp_ch.out_r2c2 = out_ff[8];

   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && singular_ff |-> out_ff[0] == '0 && out_ff[4] == '0 && out_ff[8] == '0)
      else $error("singular response with nonzero elements");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(v1_ff) && $stable(v7_ff) && $stable(div_valid[QW]))
      else $error("pipeline moved during a stall");

   a_req_enters: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> v1_ff)
      else $error("accepted request missing from first stage");

   a_singular_det: assert property (@(posedge clock) disable iff (reset)
      v6_ff |-> s6_ff.singular == (s6_ff.dmag == '0))
      else $error("singular flag disagrees with determinant");

endmodule

>>> rtl/m3inv_div_step.sv
// One restoring division step for all nine lanes, registered.
`timescale 1ns / 1ps
module m3inv_div_step (
   input  logic                  clock,
   input  logic                  reset,
   input  m3inv_pkg::ctrl_type   ctrl,
   input  m3inv_pkg::stage_type  stage_in,
   output logic                  valid_out,
   output m3inv_pkg::stage_type  stage_out
);

   logic                 valid_ff;
   m3inv_pkg::stage_type stage_ff, stage_in_next;

   always_comb begin
      logic [m3inv_pkg::REM_W-1:0] r2;
      logic [m3inv_pkg::REM_W-1:0] dext;
      logic                        ge;
      stage_in_next = stage_in;
      dext = {1'b0, stage_in.dmag};
      for (int l = 0; l < m3inv_pkg::NUM_ELEM; l++) begin
         // shift in the next numerator bit, subtract when the divisor fits
         r2 = {stage_in.lane[l].rem[m3inv_pkg::REM_W-2:0],
               stage_in.lane[l].low[m3inv_pkg::LOW_W-1]};
         ge = (r2 >= dext);
         stage_in_next.lane[l].rem = ge ? (r2 - dext) : r2;
         stage_in_next.lane[l].low = {stage_in.lane[l].low[m3inv_pkg::LOW_W-2:0], 1'b0};
         stage_in_next.lane[l].quo = {stage_in.lane[l].quo[m3inv_pkg::QUO_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.en) begin
         valid_ff <= ctrl.valid;
      end
      if (ctrl.en) begin
         stage_ff <= stage_in_next;
      end
   end

   assign valid_out = valid_ff;
   assign stage_out = stage_ff;

endmodule

>>> test/m3inv_checker.sv
// Checker for the 3x3 matrix inverse core: predicts each response and compares it.
`timescale 1ns / 1ps
module m3inv_checker (
   input logic       clock,
   input logic       reset,
   m3inv_req_if      req_ch,
   m3inv_rsp_if      rsp_ch,
   output int        fail_count,
   output int        pending_count
);

   typedef logic signed [m3inv_pkg::DATA_W-1:0] elem_type;
   typedef struct {
      elem_type elem [m3inv_pkg::NUM_ELEM];
      logic     singular;
   } inverse_type;

   inverse_type expected_inverses [$];
   int          mismatch_count;

   // Exact adjugate-over-determinant inverse, truncated and saturated.
   function automatic inverse_type compute_inverse(elem_type m [m3inv_pkg::NUM_ELEM]);
      inverse_type res;
      logic signed [m3inv_pkg::COF_W-1:0] cof [m3inv_pkg::NUM_ELEM];
      logic signed [127:0] det, num, quo, lim_hi, lim_lo;
      int r, c;
      lim_hi = 128'sh7FFFFFFF;
      lim_lo = -128'sh80000000;
      cof[0] = 64'(m[4]) * 64'(m[8]) - 64'(m[5]) * 64'(m[7]);
      cof[1] = 64'(m[5]) * 64'(m[6]) - 64'(m[3]) * 64'(m[8]);
      cof[2] = 64'(m[3]) * 64'(m[7]) - 64'(m[4]) * 64'(m[6]);
      cof[3] = 64'(m[2]) * 64'(m[7]) - 64'(m[1]) * 64'(m[8]);
      cof[4] = 64'(m[0]) * 64'(m[8]) - 64'(m[2]) * 64'(m[6]);
      cof[5] = 64'(m[1]) * 64'(m[6]) - 64'(m[0]) * 64'(m[7]);
      cof[6] = 64'(m[1]) * 64'(m[5]) - 64'(m[2]) * 64'(m[4]);
      cof[7] = 64'(m[2]) * 64'(m[3]) - 64'(m[0]) * 64'(m[5]);
      cof[8] = 64'(m[0]) * 64'(m[4]) - 64'(m[1]) * 64'(m[3]);
      det = 128'(m[0]) * 128'(cof[0]) + 128'(m[1]) * 128'(cof[1])
          + 128'(m[2]) * 128'(cof[2]);
      res.singular = (det == 0);
      for (r = 0; r < 3; r++) begin
         for (c = 0; c < 3; c++) begin
            if (res.singular) begin
               res.elem[r*3+c] = '0;
            end else begin
               // cofactor (c,r) of row-major storage, transposed
               num = 128'(cof[c*3+r]) <<< (2 * m3inv_pkg::FRAC_BITS);
               quo = num / det;
               if (quo > lim_hi) res.elem[r*3+c] = 32'h7FFFFFFF;
               else if (quo < lim_lo) res.elem[r*3+c] = 32'h80000000;
               else res.elem[r*3+c] = quo[31:0];
            end
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      elem_type m [m3inv_pkg::NUM_ELEM];
      elem_type got [m3inv_pkg::NUM_ELEM];
      inverse_type want;
      logic bad;
      if (reset) begin
         fail_count <= 0;
         mismatch_count = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            m = '{req_ch.in_r0c0, req_ch.in_r0c1, req_ch.in_r0c2,
                  req_ch.in_r1c0, req_ch.in_r1c1, req_ch.in_r1c2,
                  req_ch.in_r2c0, req_ch.in_r2c1, req_ch.in_r2c2};
            expected_inverses.push_back(compute_inverse(m));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.out_r0c0, rsp_ch.out_r0c1, rsp_ch.out_r0c2,
                    rsp_ch.out_r1c0, rsp_ch.out_r1c1, rsp_ch.out_r1c2,
                    rsp_ch.out_r2c0, rsp_ch.out_r2c1, rsp_ch.out_r2c2};
            if (expected_inverses.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("unexpected response at %0t", $realtime);
            end else begin
               want = expected_inverses.pop_front();
               bad = (rsp_ch.singular !== want.singular);
               for (int k = 0; k < m3inv_pkg::NUM_ELEM; k++)
                  if (got[k] !== want.elem[k]) bad = 1'b1;
               if (bad) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("mismatch at %0t: singular exp %0b got %0b",
                              $realtime, want.singular, rsp_ch.singular);
                     for (int k = 0; k < m3inv_pkg::NUM_ELEM; k++)
                        $display("  elem %0d exp %h got %h", k, want.elem[k], got[k]);
                  end
               end
            end
         end
         fail_count <= mismatch_count;
      end
      pending_count <= expected_inverses.size();
   end
endmodule

>>> test/matrix3x3_inverse_core_tb.sv
// Testbench top of the 3x3 matrix inverse core: stimulus, idling and verdict.
`timescale 1ns / 1ps
module matrix3x3_inverse_core_tb;

   localparam int WATCHDOG_LIMIT = 20000;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   int   send_idle_pct;
   int   recv_idle_pct;
   bit   hold_off;
   int   stall_cycles;

   m3inv_req_if req_ch ();
   m3inv_rsp_if rsp_ch ();

   matrix3x3_inverse_core u_top (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   m3inv_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .rsp_ch       (rsp_ch),
      .fail_count   (fail_count),
      .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Receiver: random stalls, plus one long hold-off on request.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_ch.ready <= 1'b0;
            for (int k = 0; k < 200; k++) @(posedge clock);
            hold_off = 1'b0;
         end
         rsp_ch.ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: count cycles without any handshake.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic logic [31:0] rand_elem();
      case ($urandom_range(5))
         0: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
         1: return $urandom;
         2: return $signed($urandom_range(8 << 16)) - (4 << 16);
         3: return $signed($urandom_range(512)) - 256;
         default: return $signed($urandom_range(1 << 20)) - (1 << 19);
      endcase
   endfunction

   task automatic send_matrix(input logic [31:0] e [9]);
      logic taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.in_r0c0 <= e[0]; req_ch.in_r0c1 <= e[1]; req_ch.in_r0c2 <= e[2];
      req_ch.in_r1c0 <= e[3]; req_ch.in_r1c1 <= e[4]; req_ch.in_r1c2 <= e[5];
      req_ch.in_r2c0 <= e[6]; req_ch.in_r2c1 <= e[7]; req_ch.in_r2c2 <= e[8];
      do begin
         // sample ready mid-cycle, where it is settled for the coming edge
         @(negedge clock);
         taken = req_ch.ready;
         @(posedge clock);
      end while (!taken);
   endtask

   task automatic send_random(input int count);
      logic [31:0] e [9];
      for (int n = 0; n < count; n++) begin
         foreach (e[k]) e[k] = rand_elem();
         case ($urandom_range(9))
            0: begin e[3] = e[0]; e[4] = e[1]; e[5] = e[2]; end // equal rows
            1: begin e[2] = 0; e[5] = 0; e[8] = 0; end         // zero column
            2: begin // scaled identity-like diagonal
               e[1] = 0; e[2] = 0; e[3] = 0; e[5] = 0; e[6] = 0; e[7] = 0;
            end
            default: ;
         endcase
         send_matrix(e);
      end
      req_ch.valid <= 1'b0;
   endtask

   initial begin
      logic [31:0] e [9];
      logic [31:0] one;
      one = 32'h00010000;
      reset = 1'b1;
      hold_off = 1'b0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      req_ch.valid = 1'b0;
      {req_ch.in_r0c0, req_ch.in_r0c1, req_ch.in_r0c2} = '0;
      {req_ch.in_r1c0, req_ch.in_r1c1, req_ch.in_r1c2} = '0;
      {req_ch.in_r2c0, req_ch.in_r2c1, req_ch.in_r2c2} = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: identity, zero, scaled, saturating and extreme matrices.
      e = '{one, 0, 0, 0, one, 0, 0, 0, one};                 send_matrix(e);
      e = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                       send_matrix(e);
      e = '{2*one, 0, 0, 0, -4*one, 0, 0, 0, one/2};          send_matrix(e);
      e = '{1, 0, 0, 0, 1, 0, 0, 0, 1};                       send_matrix(e);
      e = '{32'h7FFFFFFF, 0, 0, 0, 32'h7FFFFFFF, 0, 0, 0, 32'h7FFFFFFF};
      send_matrix(e);
      e = '{32'h80000000, 0, 0, 0, 32'h80000000, 0, 0, 0, 32'h80000000};
      send_matrix(e);
      e = '{-1, 0, 0, 0, 1, 0, 0, 0, 1};                      send_matrix(e);
      e = '{32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
            32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF};
      send_matrix(e);
      e = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
            32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF};
      send_matrix(e);
      e = '{one, 2*one, 3*one, 4*one, 5*one, 6*one, 7*one, 8*one, 10*one};
      send_matrix(e);
      e = '{0, one, 0, one, 0, 0, 0, 0, one};                 send_matrix(e);
      e = '{one, 2*one, 3*one, 2*one, 4*one, 6*one, 0, one, one};
      send_matrix(e);
      req_ch.valid <= 1'b0;

      // Long receiver hold-off while requests keep coming.
      hold_off = 1'b1;
      send_random(100);

      send_idle_pct = 7;  recv_idle_pct = 73; send_random(350);
      send_idle_pct = 73; recv_idle_pct = 7;  send_random(350);
      send_idle_pct = 0;  recv_idle_pct = 0;  send_random(350);

      while (pending_count != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule

>>> matrix3x3_inverse_core.f
rtl/m3inv_pkg.sv
rtl/m3inv_if.sv
rtl/m3inv_div_step.sv
rtl/matrix3x3_inverse_core.sv
test/m3inv_checker.sv
test/matrix3x3_inverse_core_tb.sv
